[src/pli_pkg.sv]
package pli_pkg;

  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int VAL_W      = 32;
  localparam int IDX_W      = 6;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 32;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FEW_POINTS   = 2'd1,
    ST_NOT_INCR     = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_t;

  // One table entry: known function value above known x.
  typedef struct packed {
    logic signed [VAL_W-1:0] f;
    logic signed [VAL_W-1:0] x;
  } point_t;

endpackage

[src/pli_table_mem.sv]
module pli_table_mem
  import pli_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  point_t            wdata,
  input  logic [ADDR_W-1:0] raddr,
  output point_t            rdata
);

  point_t mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/pli_div.sv]
module pli_div
  import pli_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [63:0]      num,
  input  logic [VAL_W-1:0]        den,
  output logic                    done,
  output logic signed [VAL_W-1:0] quot
);

  // Restoring divide of |num| by den, one quotient bit per cycle. The
  // quotient is known to fit 32 bits, so the upper half of |num| is
  // already below den and serves as the starting remainder.
  logic              busy;
  logic              post;
  logic              neg;
  logic [4:0]        cnt;
  logic [VAL_W-1:0]  rem;
  logic [VAL_W-1:0]  quo;
  logic [VAL_W-1:0]  dvs;
  logic [63:0]       mag;
  logic [VAL_W:0]    rem_sh;
  logic [VAL_W:0]    rem_sub;
  logic              take;

  assign mag     = num[63] ? 64'(-num) : 64'(num);
  assign rem_sh  = {rem, quo[VAL_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign take    = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      post <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= num[63];
        rem  <= mag[63:32];
        quo  <= mag[31:0];
        dvs  <= den;
      end else if (busy) begin
        rem <= take ? rem_sub[VAL_W-1:0] : rem_sh[VAL_W-1:0];
        quo <= {quo[VAL_W-2:0], take};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          post <= 1'b1;
        end
      end else if (post) begin
        post <= 1'b0;
        done <= 1'b1;
        quot <= neg ? -$signed(quo) : $signed(quo);
      end
    end
  end

endmodule

[src/piecewise_linear_interpolator_top.sv]
// Channel   Direction  Contents
// s_axis    in         tuser: cmd; tdata: point_index, x_value, f_value
// m_axis    out        tuser: status; tdata: interp_value
// cfg       in         point_count, written when cfg_we is high
//
// A query walks the table memory, then runs the checks and, if they pass,
// the multiply and sum and the radix-2 divider, and then registers the
// result; with fewer than two points it skips to registering the result.
// Synchronous reset clears point_count and control; the table is not reset.
// A stalled m_axis holds the result and blocks the next query, not loads.
module piecewise_linear_interpolator_top
  import pli_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CNT_W-1:0]      cfg_wdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // point_index, x_value, f_value, pad
  input  logic                  s_axis_tuser,  // cmd
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // interp_value
  output logic [1:0]            m_axis_tuser   // status
);

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_DECIDE, S_MUL_L, S_MUL_R, S_SUM, S_DIV_GO, S_DIV_WAIT, S_FINISH
  } state_t;

  state_t state;

  logic [CNT_W-1:0]        point_count;
  logic [CNT_W-1:0]        n_lim;
  logic [ADDR_W-1:0]       last_idx;
  logic signed [VAL_W-1:0] xq;

  logic                    issuing;
  logic [ADDR_W-1:0]       issue_idx;
  logic                    data_vld;
  logic [ADDR_W-1:0]       data_idx;
  point_t                  rdata;
  point_t                  prev;

  logic                    found;
  logic                    order_bad;
  logic signed [VAL_W-1:0] first_x;
  logic signed [VAL_W-1:0] last_x;
  point_t                  p0;
  point_t                  p1;

  logic signed [VAL_W:0]   wl;
  logic signed [VAL_W:0]   wr;
  logic [VAL_W-1:0]        width;
  logic signed [VAL_W:0]   mul_a;
  logic signed [VAL_W-1:0] mul_b;
  logic signed [64:0]      mul_p;
  logic signed [63:0]      prod;
  logic signed [63:0]      acc;
  logic signed [63:0]      num;

  logic                    div_start;
  logic                    div_done;
  logic signed [VAL_W-1:0] div_quot;

  logic signed [VAL_W-1:0] res_value;
  status_t                 res_status;

  logic                    in_acc;
  logic                    load_we;
  logic [IDX_W-1:0]        in_index;
  logic signed [VAL_W-1:0] in_x;
  logic signed [VAL_W-1:0] in_f;
  point_t                  wpoint;

  assign in_index = s_axis_tdata[IDX_W-1:0];
  assign in_x     = s_axis_tdata[IDX_W+VAL_W-1:IDX_W];
  assign in_f     = s_axis_tdata[IDX_W+2*VAL_W-1:IDX_W+VAL_W];
  assign wpoint   = '{f: in_f, x: in_x};

  // A query waits in idle until the previous result has been taken.
  assign s_axis_tready = (state == S_IDLE) &&
                         ((s_axis_tuser == CMD_LOAD) || !m_axis_tvalid);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign load_we       = in_acc && (s_axis_tuser == CMD_LOAD) &&
                         ({1'b0, in_index} < (IDX_W + 1)'(MAX_POINTS));

  assign n_lim = (point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : point_count;

  pli_table_mem u_mem (
    .clk   (clk),
    .we    (load_we),
    .waddr (in_index[ADDR_W-1:0]),
    .wdata (wpoint),
    .raddr (issue_idx),
    .rdata (rdata)
  );

  assign mul_a = (state == S_MUL_L) ? wl : wr;
  assign mul_b = (state == S_MUL_L) ? p0.f : p1.f;
  assign mul_p = mul_a * mul_b;

  assign div_start = (state == S_DIV_GO);

  pli_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (width),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cfg_we) begin
      point_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      issuing       <= 1'b0;
      data_vld      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      issue_idx     <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      data_vld <= issuing;
      data_idx <= issue_idx;
      if (issuing) begin
        issue_idx <= issue_idx + 1'b1;
        if (issue_idx == last_idx) begin
          issuing <= 1'b0;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc && (s_axis_tuser == CMD_QUERY)) begin
            xq        <= in_x;
            last_idx  <= ADDR_W'(n_lim - 1'b1);
            found     <= 1'b0;
            order_bad <= 1'b0;
            issue_idx <= '0;
            if (n_lim < CNT_W'(2)) begin
              res_value  <= '0;
              res_status <= ST_FEW_POINTS;
              state      <= S_FINISH;
            end else begin
              issuing <= 1'b1;
              state   <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (data_vld) begin
            prev <= rdata;
            if (data_idx == '0) begin
              first_x <= rdata.x;
            end else begin
              if (rdata.x <= prev.x) begin
                order_bad <= 1'b1;
              end
              // First segment whose right end reaches the query x.
              if (!found && (xq <= rdata.x)) begin
                found <= 1'b1;
                p0    <= prev;
                p1    <= rdata;
              end
            end
            if (data_idx == last_idx) begin
              last_x <= rdata.x;
              state  <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          wl    <= {p1.x[VAL_W-1], p1.x} - {xq[VAL_W-1], xq};
          wr    <= {xq[VAL_W-1], xq} - {p0.x[VAL_W-1], p0.x};
          width <= VAL_W'({p1.x[VAL_W-1], p1.x} - {p0.x[VAL_W-1], p0.x});
          priority if (order_bad) begin
            res_value  <= '0;
            res_status <= ST_NOT_INCR;
            state      <= S_FINISH;
          end else if ((xq < first_x) || (xq > last_x) || !found) begin
            res_value  <= '0;
            res_status <= ST_OUT_OF_RANGE;
            state      <= S_FINISH;
          end else begin
            state <= S_MUL_L;
          end
        end
        S_MUL_L: begin
          prod  <= mul_p[63:0];
          state <= S_MUL_R;
        end
        S_MUL_R: begin
          acc   <= prod;
          prod  <= mul_p[63:0];
          state <= S_SUM;
        end
        S_SUM: begin
          num   <= acc + prod;
          state <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            res_value  <= div_quot;
            res_status <= ST_OK;
            state      <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= res_value;
            m_axis_tuser  <= res_status;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[bench/pli_checker.sv]
module pli_checker
  import pli_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CNT_W-1:0]      cfg_wdata,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic [1:0]            m_axis_tuser,
  output int                    fail_count,
  output int                    outstanding
);

  typedef struct {
    logic signed [VAL_W-1:0] value;
    status_t                 status;
  } answer_t;

  logic [CNT_W-1:0]        pt_count;
  logic signed [VAL_W-1:0] known_x [MAX_POINTS];
  logic signed [VAL_W-1:0] known_f [MAX_POINTS];
  answer_t                 expected_answers [$];
  answer_t                 want;
  logic [IDX_W-1:0]        load_idx;
  logic signed [VAL_W-1:0] in_x;
  logic signed [VAL_W-1:0] in_f;
  status_t                 got_status;

  initial begin
    fail_count  = 0;
    outstanding = 0;
    pt_count    = '0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      known_x[i] = '0;
      known_f[i] = '0;
    end
  end

  // Answer for a query at xq against the current table and point count.
  function automatic answer_t interpolate_at(input logic signed [VAL_W-1:0] xq);
    answer_t a;
    int      n;
    bit      found;
    longint  x0, x1, f0, f1, num;
    a.value  = '0;
    a.status = ST_OK;
    found    = 1'b0;
    n = (pt_count > MAX_POINTS) ? MAX_POINTS : int'(pt_count);
    if (n < 2) begin
      a.status = ST_FEW_POINTS;
      return a;
    end
    for (int i = 0; i + 1 < n; i++) begin
      if (known_x[i+1] <= known_x[i]) begin
        a.status = ST_NOT_INCR;
        return a;
      end
    end
    if (xq < known_x[0] || xq > known_x[n-1]) begin
      a.status = ST_OUT_OF_RANGE;
      return a;
    end
    for (int i = 0; i + 1 < n; i++) begin
      if (!found && xq <= known_x[i+1]) begin
        found = 1'b1;
        x0  = longint'(known_x[i]);
        x1  = longint'(known_x[i+1]);
        f0  = longint'(known_f[i]);
        f1  = longint'(known_f[i+1]);
        // Weights are nonnegative and sum to the segment width, so the
        // numerator fits in 64 bits and the quotient stays between f0 and f1.
        num = (x1 - longint'(xq)) * f0 + (longint'(xq) - x0) * f1;
        a.value = VAL_W'(num / (x1 - x0));
      end
    end
    if (!found) begin
      a.status = ST_OUT_OF_RANGE;
    end
    return a;
  endfunction

  task automatic flag_error(input string what);
    fail_count++;
    if (fail_count <= 10) begin
      $display("ERROR at %0t: %s", $realtime, what);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pt_count = '0;
      expected_answers.delete();
    end else begin
      // A result leaving this edge always belongs to an earlier query.
      if (m_axis_tvalid && m_axis_tready) begin
        got_status = status_t'(m_axis_tuser);
        if (expected_answers.size() == 0) begin
          flag_error($sformatf("unexpected result value %h status %s",
                               m_axis_tdata, got_status.name()));
        end else begin
          want = expected_answers.pop_front();
          if (m_axis_tdata !== want.value) begin
            flag_error($sformatf("interp_value expected %h actual %h",
                                 want.value, m_axis_tdata));
          end
          if (m_axis_tuser !== want.status) begin
            flag_error($sformatf("status expected %s actual %0d",
                                 want.status.name(), m_axis_tuser));
          end
        end
      end
      if (cfg_we) begin
        pt_count = cfg_wdata;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        load_idx = s_axis_tdata[IDX_W-1:0];
        in_x     = s_axis_tdata[IDX_W +: VAL_W];
        in_f     = s_axis_tdata[IDX_W+VAL_W +: VAL_W];
        if (s_axis_tuser == CMD_LOAD) begin
          known_x[load_idx] = in_x;
          known_f[load_idx] = in_f;
        end else begin
          expected_answers.push_back(interpolate_at(in_x));
        end
      end
    end
    outstanding = expected_answers.size();
  end

endmodule

[bench/tb_piecewise_linear_interpolator_top.sv]
module tb_piecewise_linear_interpolator_top;
  import pli_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int SETTLE_CYCLES = 120;
  localparam logic signed [VAL_W-1:0] V_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] V_MAX = 32'sh7fff_ffff;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CNT_W-1:0]      cfg_wdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // point_index, x_value, f_value, pad
  logic                  s_axis_tuser;   // cmd
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // interp_value
  logic [1:0]            m_axis_tuser;   // status

  int fail_count;
  int outstanding;
  int items_sent;
  int cur_count;
  bit calm;
  logic signed [VAL_W-1:0] tx [MAX_POINTS];

  piecewise_linear_interpolator_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  pli_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  always #10 clk = ~clk;

  // Result side: ready drops at random unless in a calm stretch.
  always @(negedge clk) begin
    m_axis_tready = calm ? 1'b1 : ($urandom_range(99) >= 22);
  end

  task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx,
                           input logic signed [VAL_W-1:0] x,
                           input logic signed [VAL_W-1:0] f);
    @(negedge clk);
    if (!calm) begin
      while ($urandom_range(99) < 22) begin
        s_axis_tvalid = 1'b0;
        @(negedge clk);
      end
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {2'b00, f, x, idx};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic load_point(input int idx, input logic signed [VAL_W-1:0] x,
                            input logic signed [VAL_W-1:0] f);
    send_item(CMD_LOAD, IDX_W'(idx), x, f);
    tx[idx] = x;
  endtask

  task automatic ask(input logic signed [VAL_W-1:0] x);
    send_item(CMD_QUERY, IDX_W'($urandom), x, $urandom);
  endtask

  // Holds the sender off until every query has been answered.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_count(input int n);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = CNT_W'(n);
    @(negedge clk);
    cfg_we    = 1'b0;
    cur_count = n;
  endtask

  // Loads entries 0..n-1 with distinct sorted x drawn from a random window,
  // optionally breaking the order at one place.
  task automatic build_table(input int n, input bit broken);
    longint vals [$];
    bit     used [longint];
    longint span, lo, v, tmp;
    int     span_bits, f_bits, k;
    logic signed [VAL_W-1:0] fv;
    span_bits = $urandom_range(7, 32);
    span = longint'(1) << span_bits;
    lo = -longint'(2147483648) + (longint'($urandom) % ((longint'(1) << 32) - span + 1));
    while (vals.size() < n) begin
      v = lo + (longint'($urandom) % span);
      if (!used.exists(v)) begin
        used[v] = 1'b1;
        vals.push_back(v);
      end
    end
    vals.sort();
    if (broken) begin
      k = $urandom_range(1, n - 1);
      if ($urandom_range(1)) begin
        vals[k] = vals[k-1];
      end else begin
        tmp = vals[k];
        vals[k] = vals[k-1];
        vals[k-1] = tmp;
      end
    end
    f_bits = $urandom_range(1) ? 32 : $urandom_range(4, 31);
    for (int i = 0; i < n; i++) begin
      fv = int'($urandom) >>> (32 - f_bits);
      load_point(i, VAL_W'(vals[i]), fv);
    end
  endtask

  task automatic random_query();
    int     n, j, r;
    longint lo, hi, gap, xv;
    n = (cur_count > MAX_POINTS) ? MAX_POINTS : cur_count;
    r = $urandom_range(99);
    xv = longint'(int'($urandom));
    if (n >= 2 && r < 70) begin
      j  = $urandom_range(0, n - 2);
      lo = longint'(tx[j]);
      hi = longint'(tx[j+1]);
      if ($urandom_range(9) == 0) begin
        xv = $urandom_range(1) ? lo : hi;
      end else if (hi > lo) begin
        xv = lo + (longint'($urandom) % (hi - lo + 1));
      end else begin
        xv = lo;
      end
    end else if (n >= 2 && r < 85) begin
      if ($urandom_range(1) && tx[0] != V_MIN) begin
        gap = longint'(tx[0]) - longint'(V_MIN);
        xv  = longint'(tx[0]) - 1 - (longint'($urandom) % gap);
      end else if (tx[n-1] != V_MAX) begin
        gap = longint'(V_MAX) - longint'(tx[n-1]);
        xv  = longint'(tx[n-1]) + 1 + (longint'($urandom) % gap);
      end
    end
    ask(VAL_W'(xv));
  endtask

  initial begin
    int phase, random_start, c, n, m;
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_LOAD;
    m_axis_tready = 1'b0;
    calm          = 1'b0;
    items_sent    = 0;
    cur_count     = 0;
    for (int i = 0; i < MAX_POINTS; i++) tx[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: empty and single-point tables, full-scale endpoints,
    // equal neighbors, queries on knots and just outside the range.
    ask(0);
    write_count(1);
    ask(V_MAX);
    load_point(0, V_MIN, V_MIN);
    load_point(1, V_MAX, V_MAX);
    write_count(2);
    ask(V_MIN);
    ask(V_MAX);
    ask(0);
    ask(-1);
    load_point(0, V_MIN, V_MAX);
    load_point(1, V_MAX, V_MIN);
    ask(32'sh1234_5678);
    ask(V_MIN + 1);
    load_point(1, V_MIN, 5);
    ask(0);
    load_point(0, -65536, 0);
    load_point(1, 0, 655360);
    load_point(2, 65536, -5);
    write_count(3);
    ask(-65537);
    ask(65537);
    ask(0);
    ask(-1);
    ask(1);
    ask(-65536);
    write_count(0);
    ask(5);

    // Random part: each phase sets a count, loads a table and queries it.
    phase = 0;
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if (phase == 0) begin
        c = MAX_POINTS;
      end else if (phase == 1) begin
        c = (1 << CNT_W) - 1;
      end else begin
        m = $urandom_range(99);
        if (m < 5)       c = $urandom_range(0, 1);
        else if (m < 12) c = MAX_POINTS;
        else             c = $urandom_range(2, 12);
      end
      write_count(c);
      calm = (phase >= 3 && phase < 6);
      n = (c > MAX_POINTS) ? MAX_POINTS : c;
      if (n >= 2) begin
        build_table(n, $urandom_range(99) < 15);
      end
      m = (n >= 2) ? $urandom_range(15, 35) : $urandom_range(3, 8);
      repeat (m) begin
        if ($urandom_range(99) < 10) begin
          load_point($urandom_range(0, MAX_POINTS - 1), $urandom, $urandom);
        end else begin
          random_query();
        end
      end
      calm = 1'b0;
      phase++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
